[hdl/oaid_pkg.sv]
// Package for the ordered array insert/delete core.
// Opcode and status codes, field widths and the control structs shared between the modules.
// No dependencies.
package oaid_pkg;

	localparam int POS_W   = 5;
	localparam int DATA_W  = 32;
	localparam int COUNT_W = 5;

	typedef enum logic [1:0] {
		OP_INSERT = 2'd0,
		OP_DELETE = 2'd1,
		OP_READ   = 2'd2,
		OP_NONE   = 2'd3
	} opcode_t;

	typedef enum logic [1:0] {
		ST_OK    = 2'd0,
		ST_RANGE = 2'd1,
		ST_FULL  = 2'd2
	} status_t;

	// Per-cycle command broadcast to every cell.
	typedef struct packed {
		logic             ins;
		logic             del;
		logic [POS_W-1:0] pos;
	} cell_ctl_t;

	// Per-transaction result from the control unit.
	typedef struct packed {
		status_t            status;
		logic               rd_ok;
		logic [COUNT_W-1:0] count;
	} ctrl_res_t;

endpackage

[hdl/oaid_if.sv]
// Handshake interfaces for the request and response channels.
// Depends on oaid_pkg for the field widths.
interface oaid_req_if
	import oaid_pkg::*;
();
	logic                     valid;
	logic                     ready;
	logic [1:0]               opcode;
	logic [POS_W-1:0]         position;
	logic signed [DATA_W-1:0] value;

	modport source (output valid, output opcode, output position, output value, input ready);
	modport sink (input valid, input opcode, input position, input value, output ready);
endinterface

interface oaid_rsp_if
	import oaid_pkg::*;
();
	logic                     valid;
	logic                     ready;
	logic [1:0]               status;
	logic signed [DATA_W-1:0] read_value;
	logic [COUNT_W-1:0]       count;

	modport source (output valid, output status, output read_value, output count, input ready);
	modport sink (input valid, input status, input read_value, input count, output ready);
endinterface

[hdl/oaid_cell.sv]
// One storage cell of the shift chain: holds a single entry.
// Shifts from its left or right neighbor on insert/delete. Depends on oaid_pkg.
module oaid_cell
	import oaid_pkg::*;
#(
	parameter int IDX_W = 5,
	parameter int IDX   = 0
) (
	input  logic                     clk,
	input  cell_ctl_t                ctl,
	input  logic signed [DATA_W-1:0] value,
	input  logic signed [DATA_W-1:0] left_data,
	input  logic signed [DATA_W-1:0] right_data,
	output logic signed [DATA_W-1:0] data,
	output logic signed [DATA_W-1:0] sel_data
);

	localparam logic [IDX_W-1:0] MY_IDX = IDX_W'(IDX);

	logic signed [DATA_W-1:0] data_q;
	logic [IDX_W-1:0]         pos_e;
	logic                     hit;
	logic                     after;

	assign pos_e = IDX_W'(ctl.pos);
	assign hit   = (pos_e == MY_IDX);
	assign after = (pos_e < MY_IDX);

	always_ff @(posedge clk) begin
		priority if (ctl.ins && hit) begin
			data_q <= value;
		end else if (ctl.ins && after) begin
			data_q <= left_data;
		end else if (ctl.del && (hit || after)) begin
			data_q <= right_data;
		end else begin
			data_q <= data_q;
		end
	end

	assign data     = data_q;
	assign sel_data = hit ? data_q : '0;

endmodule

[hdl/oaid_ctrl.sv]
// Control unit: decodes the opcode, checks the position and holds the entry count.
// Drives the cell command and the transaction status. Depends on oaid_pkg.
module oaid_ctrl
	import oaid_pkg::*;
#(
	parameter int MAX_ENTRIES = 16,
	parameter int CNT_W       = 5
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             accept,
	input  logic [1:0]       opcode,
	input  logic [POS_W-1:0] position,
	output cell_ctl_t        ctl,
	output ctrl_res_t        res
);

	localparam int CMP_W = (CNT_W > POS_W) ? CNT_W : POS_W;

	logic [CNT_W-1:0] cnt_q;
	logic [CNT_W-1:0] cnt_next;
	logic [CMP_W-1:0] pos_e;
	logic [CMP_W-1:0] cnt_e;
	logic             full;
	logic             do_ins;
	logic             do_del;
	status_t          status;
	logic             rd_ok;

	assign pos_e = CMP_W'(position);
	assign cnt_e = CMP_W'(cnt_q);
	assign full  = (cnt_q == CNT_W'(MAX_ENTRIES));

	always_comb begin
		status = ST_OK;
		rd_ok  = 1'b0;
		do_ins = 1'b0;
		do_del = 1'b0;
		unique case (opcode_t'(opcode))
			OP_INSERT: begin
				// range check takes priority over the full check
				if (pos_e > cnt_e) begin
					status = ST_RANGE;
				end else if (full) begin
					status = ST_FULL;
				end else begin
					do_ins = 1'b1;
				end
			end
			OP_DELETE: begin
				if (pos_e >= cnt_e) begin
					status = ST_RANGE;
				end else begin
					do_del = 1'b1;
				end
			end
			OP_READ: begin
				if (pos_e >= cnt_e) begin
					status = ST_RANGE;
				end else begin
					rd_ok = 1'b1;
				end
			end
			OP_NONE: begin
				status = ST_OK;
			end
		endcase
	end

	always_comb begin
		priority if (do_ins) begin
			cnt_next = cnt_q + CNT_W'(1);
		end else if (do_del) begin
			cnt_next = cnt_q - CNT_W'(1);
		end else begin
			cnt_next = cnt_q;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q <= '0;
		end else if (accept) begin
			cnt_q <= cnt_next;
		end
	end

	assign ctl.ins = accept && do_ins;
	assign ctl.del = accept && do_del;
	assign ctl.pos = position;

	assign res.status = status;
	assign res.rd_ok  = rd_ok;
	assign res.count  = COUNT_W'(cnt_next);

endmodule

[hdl/ordered_array_insert_delete_core.sv]
// Ordered array with insert, delete and read by position, built as a chain of entry cells.
// The response is registered and valid in the cycle after the request transaction.
// One transaction per cycle unless rsp stalls; shifting cells update with the count.
// Reset: entry count cleared and response register empty; entry contents are not reset.
module ordered_array_insert_delete_core
	import oaid_pkg::*;
#(
	parameter int MAX_ENTRIES = 16
) (
	input  logic       clk,
	input  logic       arst_n,
	oaid_req_if.sink   req,
	oaid_rsp_if.source rsp
);

	localparam int CNT_W = $clog2(MAX_ENTRIES + 1);
	localparam int IDX_W = (CNT_W > POS_W) ? CNT_W : POS_W;

	logic                     accept;
	cell_ctl_t                ctl;
	ctrl_res_t                res;
	logic signed [DATA_W-1:0] cell_data [MAX_ENTRIES];
	logic signed [DATA_W-1:0] cell_sel  [MAX_ENTRIES];
	logic signed [DATA_W-1:0] rd_or;

	logic                     out_valid_q;
	logic [1:0]               status_q;
	logic signed [DATA_W-1:0] read_value_q;
	logic [COUNT_W-1:0]       count_q;

	assign req.ready = !out_valid_q || rsp.ready;
	assign accept    = req.valid && req.ready;

	oaid_ctrl #(
		.MAX_ENTRIES (MAX_ENTRIES),
		.CNT_W       (CNT_W)
	) u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.accept   (accept),
		.opcode   (req.opcode),
		.position (req.position),
		.ctl      (ctl),
		.res      (res)
	);

	for (genvar i = 0; i < MAX_ENTRIES; i++) begin : g_cell
		logic signed [DATA_W-1:0] left_d;
		logic signed [DATA_W-1:0] right_d;

		if (i == 0) begin : g_first
			assign left_d = '0;
		end else begin : g_mid_l
			assign left_d = cell_data[i-1];
		end

		if (i == MAX_ENTRIES - 1) begin : g_last
			assign right_d = '0;
		end else begin : g_mid_r
			assign right_d = cell_data[i+1];
		end

		oaid_cell #(
			.IDX_W (IDX_W),
			.IDX   (i)
		) u_cell (
			.clk        (clk),
			.ctl        (ctl),
			.value      (req.value),
			.left_data  (left_d),
			.right_data (right_d),
			.data       (cell_data[i]),
			.sel_data   (cell_sel[i])
		);
	end

	// at most one cell matches the position
	always_comb begin
		rd_or = '0;
		for (int i = 0; i < MAX_ENTRIES; i++) begin
			rd_or = rd_or | cell_sel[i];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (accept) begin
			out_valid_q <= 1'b1;
		end else if (rsp.ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			status_q     <= res.status;
			read_value_q <= res.rd_ok ? rd_or : '0;
			count_q      <= res.count;
		end
	end

	assign rsp.valid      = out_valid_q;
	assign rsp.status     = status_q;
	assign rsp.read_value = read_value_q;
	assign rsp.count      = count_q;

`ifndef NO_ASSERTIONS
	a_accept_gives_rsp: assert property (@(posedge clk) disable iff (!arst_n)
		accept |=> rsp.valid)
		else $error("accepted transaction produced no response");

	a_error_no_data: assert property (@(posedge clk) disable iff (!arst_n)
		(rsp.valid && rsp.status != ST_OK) |-> (rsp.read_value == '0))
		else $error("read data nonzero on error status");

	a_full_count: assert property (@(posedge clk) disable iff (!arst_n)
		(rsp.valid && rsp.status == ST_FULL) |-> (rsp.count == COUNT_W'(MAX_ENTRIES)))
		else $error("full status with count below capacity");
`endif

endmodule

[tb/tb_top.sv]
`timescale 1ns / 100ps
// Self-checking testbench for ordered_array_insert_delete_core: directed table, then random traffic.
// Depends on oaid_pkg, oaid_req_if / oaid_rsp_if and the core RTL.
module tb_top;
	import oaid_pkg::*;

	localparam int LIST_DEPTH = 16;
	localparam int QUIET_LIMIT = 1000;
	localparam int RAND_ITEMS = 900;
	localparam int CALM_ITEMS = 150;
	localparam int DIR_ROWS = 25;

	typedef struct packed {
		status_t                  status;
		logic signed [DATA_W-1:0] read_value;
		logic [COUNT_W-1:0]       count;
	} list_result_t;

	typedef struct {
		opcode_t            op;
		logic [POS_W-1:0]   pos;
		logic [DATA_W-1:0]  val;
		int                 reps;
		bit                 typed;
		status_t            st;
		logic [DATA_W-1:0]  rd;
		logic [COUNT_W-1:0] cnt;
	} stim_row_t;

	logic clk;
	logic arst_n;

	oaid_req_if req ();
	oaid_rsp_if rsp ();

	ordered_array_insert_delete_core #(
		.MAX_ENTRIES(LIST_DEPTH)
	) dut (
		.clk(clk),
		.arst_n(arst_n),
		.req(req),
		.rsp(rsp)
	);

	logic signed [DATA_W-1:0] list_words [LIST_DEPTH];
	int                       list_len;
	list_result_t             pending_results [$];
	int                       error_count;
	bit                       idle_on;

	// rows with typed results only where the answer is obvious; reps > 1 repeats with val + k
	stim_row_t dir_table [DIR_ROWS] = '{
		'{OP_READ,   5'd0,  32'h0,        1,  1'b1, ST_RANGE, 32'h0,        5'd0},
		'{OP_DELETE, 5'd0,  32'h0,        1,  1'b1, ST_RANGE, 32'h0,        5'd0},
		'{OP_INSERT, 5'd1,  32'h5,        1,  1'b1, ST_RANGE, 32'h0,        5'd0},
		'{OP_NONE,   5'd31, 32'hFFFFFFFF, 1,  1'b1, ST_OK,    32'h0,        5'd0},
		'{OP_INSERT, 5'd0,  32'h80000000, 1,  1'b1, ST_OK,    32'h0,        5'd1},
		'{OP_READ,   5'd0,  32'h0,        1,  1'b1, ST_OK,    32'h80000000, 5'd1},
		'{OP_INSERT, 5'd1,  32'h7FFFFFFF, 1,  1'b1, ST_OK,    32'h0,        5'd2},
		'{OP_READ,   5'd1,  32'h0,        1,  1'b1, ST_OK,    32'h7FFFFFFF, 5'd2},
		'{OP_READ,   5'd2,  32'h0,        1,  1'b1, ST_RANGE, 32'h0,        5'd2},
		'{OP_DELETE, 5'd0,  32'h0,        1,  1'b1, ST_OK,    32'h0,        5'd1},
		// removing the only entry must empty the list
		'{OP_DELETE, 5'd0,  32'h0,        1,  1'b1, ST_OK,    32'h0,        5'd0},
		'{OP_INSERT, 5'd0,  32'h100,      16, 1'b0, ST_OK,    32'h0,        5'd0},
		'{OP_INSERT, 5'd16, 32'h1,        1,  1'b1, ST_FULL,  32'h0,        5'd16},
		// position check wins over the full check
		'{OP_INSERT, 5'd17, 32'h1,        1,  1'b1, ST_RANGE, 32'h0,        5'd16},
		'{OP_INSERT, 5'd31, 32'h1,        1,  1'b1, ST_RANGE, 32'h0,        5'd16},
		'{OP_READ,   5'd16, 32'h0,        1,  1'b1, ST_RANGE, 32'h0,        5'd16},
		'{OP_READ,   5'd15, 32'h0,        1,  1'b1, ST_OK,    32'h100,      5'd16},
		'{OP_READ,   5'd0,  32'h0,        1,  1'b1, ST_OK,    32'h10F,      5'd16},
		'{OP_DELETE, 5'd16, 32'h0,        1,  1'b1, ST_RANGE, 32'h0,        5'd16},
		'{OP_DELETE, 5'd7,  32'h0,        1,  1'b1, ST_OK,    32'h0,        5'd15},
		'{OP_INSERT, 5'd15, 32'hAAAA5555, 1,  1'b1, ST_OK,    32'h0,        5'd16},
		'{OP_READ,   5'd15, 32'h0,        1,  1'b1, ST_OK,    32'hAAAA5555, 5'd16},
		'{OP_NONE,   5'd0,  32'h0,        1,  1'b1, ST_OK,    32'h0,        5'd16},
		'{OP_DELETE, 5'd0,  32'h0,        16, 1'b0, ST_OK,    32'h0,        5'd0},
		'{OP_READ,   5'd0,  32'h0,        1,  1'b1, ST_RANGE, 32'h0,        5'd0}
	};

	initial begin
		clk = 1'b0;
		forever #2 clk = ~clk;
	end

	task automatic flag_mismatch(input string msg);
		$display("MISMATCH @%0t: %s", $time, msg);
		error_count++;
	endtask

	// Updates the shadow list and returns what the core should answer.
	function automatic list_result_t apply_list_op(input logic [1:0] op,
			input logic [POS_W-1:0] pos, input logic signed [DATA_W-1:0] val);
		list_result_t r;
		r.status = ST_OK;
		r.read_value = '0;
		case (opcode_t'(op))
			OP_INSERT: begin
				if (pos > list_len)
					r.status = ST_RANGE;
				else if (list_len >= LIST_DEPTH)
					r.status = ST_FULL;
				else begin
					for (int i = list_len; i > pos; i--)
						list_words[i] = list_words[i-1];
					list_words[pos] = val;
					list_len++;
				end
			end
			OP_DELETE: begin
				if (pos >= list_len)
					r.status = ST_RANGE;
				else begin
					for (int i = pos; i + 1 < list_len; i++)
						list_words[i] = list_words[i+1];
					list_len--;
				end
			end
			OP_READ: begin
				if (pos >= list_len)
					r.status = ST_RANGE;
				else
					r.read_value = list_words[pos];
			end
			default: ;
		endcase
		r.count = list_len[COUNT_W-1:0];
		return r;
	endfunction

	// Drives one request; prediction is made at the accepting edge.
	task automatic send_op(input logic [1:0] op, input logic [POS_W-1:0] pos,
			input logic [DATA_W-1:0] val, input bit typed, input list_result_t want);
		list_result_t predicted;
		if (idle_on && $urandom_range(0, 4) == 0) begin
			req.valid <= 1'b0;
			repeat ($urandom_range(1, 18)) @(posedge clk);
		end
		req.valid <= 1'b1;
		req.opcode <= op;
		req.position <= pos;
		req.value <= val;
		@(posedge clk);
		while (!req.ready) @(posedge clk);
		predicted = apply_list_op(op, pos, val);
		pending_results.push_back(typed ? want : predicted);
	endtask

	function automatic logic [DATA_W-1:0] pick_value();
		case ($urandom_range(0, 9))
			0: return 32'h80000000;
			1: return 32'h7FFFFFFF;
			2: return 32'h0;
			3: return 32'hFFFFFFFF;
			default: return $urandom;
		endcase
	endfunction

	// Position biased toward both ends of the valid range [0, hi].
	function automatic logic [POS_W-1:0] pick_position(input int hi);
		case ($urandom_range(0, 3))
			0: return '0;
			1: return hi[POS_W-1:0];
			default: return POS_W'($urandom_range(0, hi));
		endcase
	endfunction

	// response checker
	always @(posedge clk) begin
		list_result_t want;
		if (arst_n && rsp.valid && rsp.ready) begin
			if (pending_results.size() == 0)
				flag_mismatch("response with no transaction pending");
			else begin
				want = pending_results.pop_front();
				if (rsp.status !== want.status)
					flag_mismatch($sformatf("status %0d, want %0d", rsp.status, want.status));
				if (rsp.read_value !== want.read_value)
					flag_mismatch($sformatf("read_value %0d, want %0d",
						rsp.read_value, want.read_value));
				if (rsp.count !== want.count)
					flag_mismatch($sformatf("count %0d, want %0d", rsp.count, want.count));
			end
		end
	end

	// response back-pressure in random bursts
	initial begin
		rsp.ready <= 1'b1;
		forever begin
			@(posedge clk);
			if (idle_on && $urandom_range(0, 9) == 0) begin
				rsp.ready <= 1'b0;
				repeat ($urandom_range(1, 18)) @(posedge clk);
				rsp.ready <= 1'b1;
			end
		end
	end

	// watchdog: too long without any transaction on either channel
	initial begin
		int quiet_cycles;
		quiet_cycles = 0;
		while (quiet_cycles < QUIET_LIMIT) begin
			@(posedge clk);
			if ((req.valid && req.ready) || (rsp.valid && rsp.ready))
				quiet_cycles = 0;
			else
				quiet_cycles++;
		end
		$display("ordered_array_insert_delete_core test failed");
		$finish;
	end

	initial begin
		list_result_t none;
		int pct_insert;
		int sel;
		logic [1:0] op;
		logic [POS_W-1:0] pos;
		none = '0;
		error_count = 0;
		list_len = 0;
		idle_on = 1'b1;
		pct_insert = 50;
		arst_n <= 1'b0;
		req.valid <= 1'b0;
		req.opcode <= OP_NONE;
		req.position <= '0;
		req.value <= '0;
		repeat (11) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		foreach (dir_table[r]) begin
			for (int k = 0; k < dir_table[r].reps; k++)
				send_op(dir_table[r].op, dir_table[r].pos, dir_table[r].val + k,
					dir_table[r].typed,
					'{dir_table[r].st, dir_table[r].rd, dir_table[r].cnt});
		end

		for (int n = 0; n < RAND_ITEMS; n++) begin
			idle_on = (n < RAND_ITEMS - CALM_ITEMS);
			// drift between filling, balanced and draining phases
			if (n % 50 == 0) begin
				case ($urandom_range(0, 2))
					0: pct_insert = 85;
					1: pct_insert = 50;
					default: pct_insert = 15;
				endcase
			end
			sel = $urandom_range(0, 99);
			if (sel < 5) begin
				op = OP_NONE;
				pos = POS_W'($urandom_range(0, 31));
			end else if (sel < 12) begin
				op = 2'($urandom_range(0, 2));
				pos = POS_W'($urandom_range(0, 31));
			end else if ($urandom_range(0, 99) < pct_insert) begin
				op = OP_INSERT;
				pos = pick_position(list_len);
			end else begin
				op = ($urandom_range(0, 1) == 0) ? OP_DELETE : OP_READ;
				pos = (list_len == 0) ? POS_W'($urandom_range(0, 31))
					: pick_position(list_len - 1);
			end
			send_op(op, pos, pick_value(), 1'b0, none);
		end
		req.valid <= 1'b0;

		while (pending_results.size() != 0) @(posedge clk);
		repeat (8) @(posedge clk);
		if (error_count == 0)
			$display("ordered_array_insert_delete_core test passed");
		else
			$display("ordered_array_insert_delete_core test failed");
		$finish;
	end

endmodule

[sim.f]
hdl/oaid_pkg.sv
hdl/oaid_if.sv
hdl/oaid_cell.sv
hdl/oaid_ctrl.sv
hdl/ordered_array_insert_delete_core.sv
tb/tb_top.sv
